// File: hw/rtl/rbpb_pkg.sv
// Shared types, widths and register codes for the rotated box pixel binner.
package rbpb_pkg;

  localparam int MAX_BINS_X      = 1024;
  localparam int MAX_BINS_Y      = 1024;
  localparam int COORD_FRAC_BITS = 16;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int BPU_FRAC_BITS   = 16;
  localparam int SCALE_FRAC      = COORD_FRAC_BITS + BPU_FRAC_BITS;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 18;
  localparam int BPU_W   = 32;
  localparam int CNT_W   = 11;
  localparam int PIX_W   = 21;
  localparam int CFG_W   = 32;

  // rotation datapath
  localparam int PROD_W = COORD_W + ANGLE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ROT_W  = SUM_W - ANGLE_FRAC_BITS;
  localparam int DIFF_W = ((ROT_W > COORD_W) ? ROT_W : COORD_W) + 1;

  // scaling datapath: the positive difference is split at bit 32
  localparam int SPLIT_W = 32;
  localparam int DHI_W   = DIFF_W - 1 - SPLIT_W;
  localparam int PLO_W   = SPLIT_W + BPU_W;
  localparam int PHI_W   = DHI_W + BPU_W;
  localparam int FULL_W  = DIFF_W - 1 + BPU_W;
  localparam int IP_W    = FULL_W - SCALE_FRAC;

  localparam int COL_W   = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int ROW_W   = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int WHOLE_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int IDX_SUM_W = WHOLE_W + CNT_W + 1;
  localparam int IDX_W   = (IDX_SUM_W > PIX_W) ? IDX_SUM_W : PIX_W;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_ANGLE       = 3'd0,
    CFG_SIN_ANGLE       = 3'd1,
    CFG_ORIGIN_X        = 3'd2,
    CFG_ORIGIN_Y        = 3'd3,
    CFG_BINS_PER_UNIT_X = 3'd4,
    CFG_BINS_PER_UNIT_Y = 3'd5,
    CFG_BIN_COUNT_X     = 3'd6,
    CFG_BIN_COUNT_Y     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_sample;
  } sample_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic             last_out;
  } result_t;

  // register contents as used by the datapath, counts already saturated
  typedef struct packed {
    logic signed [ANGLE_W-1:0] cos_angle;
    logic signed [ANGLE_W-1:0] sin_angle;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [BPU_W-1:0]          bins_per_unit_x;
    logic [BPU_W-1:0]          bins_per_unit_y;
    logic [CNT_W-1:0]          bin_count_x;
    logic [CNT_W-1:0]          bin_count_y;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic               hit;
    logic [WHOLE_W-1:0] whole;
  } axis_t;

endpackage

// File: hw/rtl/rbpb_cfg_regs.sv
// Configuration register file with bin count saturation.
module rbpb_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbpb_pkg::CFG_W-1:0]      cfg_data_i,
  output rbpb_pkg::cfg_t                  cfg_o
);
  import rbpb_pkg::*;

  logic signed [ANGLE_W-1:0] cos_q, sin_q;
  logic signed [COORD_W-1:0] org_x_q, org_y_q;
  logic [BPU_W-1:0]          bpu_x_q, bpu_y_q;
  logic [CNT_W-1:0]          cnt_x_q, cnt_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= ANGLE_W'(65536);
      sin_q   <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
      bpu_x_q <= BPU_W'(65536);
      bpu_y_q <= BPU_W'(65536);
      cnt_x_q <= CNT_W'(1);
      cnt_y_q <= CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COS_ANGLE:       cos_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_SIN_ANGLE:       sin_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_ORIGIN_X:        org_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y:        org_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_BINS_PER_UNIT_X: bpu_x_q <= cfg_data_i[BPU_W-1:0];
        CFG_BINS_PER_UNIT_Y: bpu_y_q <= cfg_data_i[BPU_W-1:0];
        CFG_BIN_COUNT_X:     cnt_x_q <= cfg_data_i[CNT_W-1:0];
        CFG_BIN_COUNT_Y:     cnt_y_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    cfg_o.cos_angle       = cos_q;
    cfg_o.sin_angle       = sin_q;
    cfg_o.origin_x        = org_x_q;
    cfg_o.origin_y        = org_y_q;
    cfg_o.bins_per_unit_x = bpu_x_q;
    cfg_o.bins_per_unit_y = bpu_y_q;
    cfg_o.bin_count_x = (int'(cnt_x_q) > MAX_BINS_X) ? CNT_W'(MAX_BINS_X) : cnt_x_q;
    cfg_o.bin_count_y = (int'(cnt_y_q) > MAX_BINS_Y) ? CNT_W'(MAX_BINS_Y) : cnt_y_q;
  end

endmodule

// File: hw/rtl/rbpb_rotate.sv
// Rotation and origin subtraction: products, floored sums, differences.
module rbpb_rotate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  rbpb_pkg::sample_t                  sample_i,
  input  rbpb_pkg::cfg_t                     cfg_i,
  output rbpb_pkg::tag_t                     tag_o,
  output logic signed [rbpb_pkg::DIFF_W-1:0] diff_x_o,
  output logic signed [rbpb_pkg::DIFF_W-1:0] diff_y_o
);
  import rbpb_pkg::*;

  tag_t tag_a_q, tag_b_q, tag_c_q;

  logic signed [PROD_W-1:0] p_xc_d, p_ys_d, p_xs_d, p_yc_d;
  logic signed [PROD_W-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [ROT_W-1:0]  rot_x_d, rot_y_d, rot_x_q, rot_y_q;
  logic signed [DIFF_W-1:0] diff_x_d, diff_y_d, diff_x_q, diff_y_q;

  always_comb begin
    p_xc_d = PROD_W'(sample_i.coord_x) * PROD_W'(cfg_i.cos_angle);
    p_ys_d = PROD_W'(sample_i.coord_y) * PROD_W'(cfg_i.sin_angle);
    p_xs_d = PROD_W'(sample_i.coord_x) * PROD_W'(cfg_i.sin_angle);
    p_yc_d = PROD_W'(sample_i.coord_y) * PROD_W'(cfg_i.cos_angle);

    sum_x = SUM_W'(p_xc_q) - SUM_W'(p_ys_q);
    sum_y = SUM_W'(p_xs_q) + SUM_W'(p_yc_q);
    // dropping the low bits of a two's complement value floors it
    rot_x_d = sum_x[SUM_W-1:ANGLE_FRAC_BITS];
    rot_y_d = sum_y[SUM_W-1:ANGLE_FRAC_BITS];

    diff_x_d = DIFF_W'(rot_x_q) - DIFF_W'(cfg_i.origin_x);
    diff_y_d = DIFF_W'(rot_y_q) - DIFF_W'(cfg_i.origin_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= '{valid: valid_i, last: sample_i.last_sample};
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p_xc_q <= p_xc_d;
      p_ys_q <= p_ys_d;
      p_xs_q <= p_xs_d;
      p_yc_q <= p_yc_d;
    end
    if (tag_a_q.valid) begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
    end
    if (tag_b_q.valid) begin
      diff_x_q <= diff_x_d;
      diff_y_q <= diff_y_d;
    end
  end

  assign tag_o    = tag_c_q;
  assign diff_x_o = diff_x_q;
  assign diff_y_o = diff_y_q;

endmodule

// File: hw/rtl/rbpb_scale.sv
// Scaling to bin units and strict range test, both axes in parallel lanes.
module rbpb_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rbpb_pkg::tag_t                     tag_i,
  input  logic signed [rbpb_pkg::DIFF_W-1:0] diff_x_i,
  input  logic signed [rbpb_pkg::DIFF_W-1:0] diff_y_i,
  input  rbpb_pkg::cfg_t                     cfg_i,
  output rbpb_pkg::tag_t                     tag_o,
  output rbpb_pkg::axis_t                    axis_x_o,
  output rbpb_pkg::axis_t                    axis_y_o
);
  import rbpb_pkg::*;

  tag_t tag_d_q, tag_e_q, tag_f_q;

  logic signed [DIFF_W-1:0] diff  [2];
  logic [BPU_W-1:0]         scale [2];
  logic [CNT_W-1:0]         count [2];

  logic              pos_d   [2];
  logic              pos_q   [2];
  logic              pos_e_q [2];
  logic [PLO_W-1:0]  plo_d   [2];
  logic [PLO_W-1:0]  plo_q   [2];
  logic [PHI_W-1:0]  phi_d   [2];
  logic [PHI_W-1:0]  phi_q   [2];
  logic [FULL_W-1:0] full_d  [2];
  logic [FULL_W-1:0] full_q  [2];
  logic [IP_W-1:0]   ip      [2];
  axis_t             axis_d  [2];
  axis_t             axis_q  [2];

  always_comb begin
    diff[0]  = diff_x_i;
    diff[1]  = diff_y_i;
    scale[0] = cfg_i.bins_per_unit_x;
    scale[1] = cfg_i.bins_per_unit_y;
    count[0] = cfg_i.bin_count_x;
    count[1] = cfg_i.bin_count_y;

    for (int i = 0; i < 2; i++) begin
      // a positive difference times a non-zero scale is never zero, so
      // the lower bound reduces to the two sign and zero tests
      pos_d[i] = (diff[i] > 0) && (scale[i] != '0);
      plo_d[i] = PLO_W'(diff[i][SPLIT_W-1:0]) * PLO_W'(scale[i]);
      phi_d[i] = PHI_W'(diff[i][DIFF_W-2:SPLIT_W]) * PHI_W'(scale[i]);

      full_d[i] = {phi_q[i], {SPLIT_W{1'b0}}} + FULL_W'(plo_q[i]);

      ip[i] = full_q[i][FULL_W-1:SCALE_FRAC];
      axis_d[i].hit   = pos_e_q[i] && (ip[i] < IP_W'(count[i]));
      axis_d[i].whole = ip[i][WHOLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_d_q <= '0;
      tag_e_q <= '0;
      tag_f_q <= '0;
    end else begin
      tag_d_q <= tag_i;
      tag_e_q <= tag_d_q;
      tag_f_q <= tag_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      if (tag_i.valid) begin
        pos_q[i] <= pos_d[i];
        plo_q[i] <= plo_d[i];
        phi_q[i] <= phi_d[i];
      end
      if (tag_d_q.valid) begin
        pos_e_q[i] <= pos_q[i];
        full_q[i]  <= full_d[i];
      end
      if (tag_e_q.valid) begin
        axis_q[i] <= axis_d[i];
      end
    end
  end

  assign tag_o    = tag_f_q;
  assign axis_x_o = axis_q[0];
  assign axis_y_o = axis_q[1];

endmodule

// File: hw/rtl/rbpb_index.sv
// Pixel index: column plus row times columns plus one, zero when outside.
module rbpb_index (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbpb_pkg::tag_t               tag_i,
  input  rbpb_pkg::axis_t              axis_x_i,
  input  rbpb_pkg::axis_t              axis_y_i,
  input  logic [rbpb_pkg::CNT_W-1:0]   bin_count_x_i,
  output logic                         done_o,
  output rbpb_pkg::result_t            result_o
);
  import rbpb_pkg::*;

  logic             valid_q;
  logic [IDX_W-1:0] idx_sum;
  result_t          res_d, res_q;

  always_comb begin
    idx_sum = IDX_W'(axis_y_i.whole[ROW_W-1:0]) * IDX_W'(bin_count_x_i)
            + IDX_W'(axis_x_i.whole[COL_W-1:0]) + IDX_W'(1);
    res_d.pixel_index = (axis_x_i.hit && axis_y_i.hit) ? idx_sum[PIX_W-1:0] : '0;
    res_d.last_out    = tag_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      res_q <= res_d;
    end
  end

  assign done_o   = valid_q;
  assign result_o = res_q;

endmodule

// File: hw/rtl/rotated_box_pixel_binner.sv
// Top level of the rotated box pixel binner.
// Takes one sample per cycle on start; busy is always low. Every sample gives
// exactly one result, shown for one cycle with done_o high, after the beat
// passes three rotation stages, three scaling stages and one index
// stage. Results come out in input order and cannot be held off. Register
// writes are taken at once; write them only while no sample is in flight.
module rotated_box_pixel_binner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rbpb_pkg::sample_t              sample_i,
  output logic                           done_o,
  output rbpb_pkg::result_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbpb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbpb_pkg::CFG_W-1:0]     cfg_data_i
);
  import rbpb_pkg::*;

  cfg_t                     cfg;
  tag_t                     rot_tag, scl_tag;
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  axis_t                    axis_x, axis_y;

  assign busy = 1'b0;

  rbpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rbpb_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .tag_o    (rot_tag),
    .diff_x_o (diff_x),
    .diff_y_o (diff_y)
  );

  rbpb_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rot_tag),
    .diff_x_i (diff_x),
    .diff_y_i (diff_y),
    .cfg_i    (cfg),
    .tag_o    (scl_tag),
    .axis_x_o (axis_x),
    .axis_y_o (axis_y)
  );

  rbpb_index u_index (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (scl_tag),
    .axis_x_i      (axis_x),
    .axis_y_i      (axis_y),
    .bin_count_x_i (cfg.bin_count_x),
    .done_o        (done_o),
    .result_o      (result_o)
  );

endmodule

// File: test/rbpb_bin_checker.sv
// Checker for the rotated box pixel binner: predicts each pixel index and compares results.
`timescale 1ns / 1ps
module rbpb_bin_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  rbpb_pkg::sample_t              sample_i,
  input  logic                           done_i,
  input  rbpb_pkg::result_t              result_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rbpb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbpb_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             inside_o
);
  import rbpb_pkg::*;

  // shadow of the register file
  logic signed [ANGLE_W-1:0] cos_q, sin_q;
  logic signed [COORD_W-1:0] org_x, org_y;
  logic [BPU_W-1:0]          bpu_x, bpu_y;
  logic [CNT_W-1:0]          cnt_x, cnt_y;

  result_t expected_bins[$];
  result_t exp_r;

  // 0 < d*scale < count, with the floor of the product returned in whole
  function automatic bit axis_bin(longint d, logic [BPU_W-1:0] scale,
                                  longint unsigned count, output longint unsigned whole);
    logic [127:0] prod;
    whole = 0;
    if (d <= 0 || scale == '0) return 1'b0;
    prod = {64'd0, d} * {96'd0, scale};
    if (prod == '0 || prod[127:SCALE_FRAC] >= 96'(count)) return 1'b0;
    whole = prod[SCALE_FRAC+63:SCALE_FRAC];
    return 1'b1;
  endfunction

  function automatic result_t bin_sample(sample_t s);
    longint          rx, ry, dx, dy;
    longint unsigned nx, ny, col, row, pix;
    result_t         r;
    nx = (cnt_x > MAX_BINS_X) ? MAX_BINS_X : cnt_x;
    ny = (cnt_y > MAX_BINS_Y) ? MAX_BINS_Y : cnt_y;
    rx = (longint'(s.coord_x) * longint'(cos_q) - longint'(s.coord_y) * longint'(sin_q))
         >>> ANGLE_FRAC_BITS;
    ry = (longint'(s.coord_x) * longint'(sin_q) + longint'(s.coord_y) * longint'(cos_q))
         >>> ANGLE_FRAC_BITS;
    dx = rx - longint'(org_x);
    dy = ry - longint'(org_y);
    pix = 0;
    if (axis_bin(dx, bpu_x, nx, col) && axis_bin(dy, bpu_y, ny, row)) begin
      pix = col + row * nx + 1;
    end
    r.pixel_index = pix[PIX_W-1:0];
    r.last_out    = s.last_sample;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q        <= 18'sd65536;
      sin_q        <= '0;
      org_x        <= '0;
      org_y        <= '0;
      bpu_x        <= 32'd65536;
      bpu_y        <= 32'd65536;
      cnt_x        <= 11'd1;
      cnt_y        <= 11'd1;
      expected_bins.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      inside_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_COS_ANGLE:       cos_q <= cfg_data_i[ANGLE_W-1:0];
          CFG_SIN_ANGLE:       sin_q <= cfg_data_i[ANGLE_W-1:0];
          CFG_ORIGIN_X:        org_x <= cfg_data_i;
          CFG_ORIGIN_Y:        org_y <= cfg_data_i;
          CFG_BINS_PER_UNIT_X: bpu_x <= cfg_data_i;
          CFG_BINS_PER_UNIT_Y: bpu_y <= cfg_data_i;
          CFG_BIN_COUNT_X:     cnt_x <= cfg_data_i[CNT_W-1:0];
          CFG_BIN_COUNT_Y:     cnt_y <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_bins.push_back(bin_sample(sample_i));
      if (done_i) begin
        checked_o <= checked_o + 1;
        if (expected_bins.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("ERROR: result with nothing outstanding: pixel_index %0d last_out %0b",
                     result_i.pixel_index, result_i.last_out);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_bins.pop_front();
          if (exp_r.pixel_index != 0) inside_o <= inside_o + 1;
          if (result_i.pixel_index !== exp_r.pixel_index ||
              result_i.last_out !== exp_r.last_out) begin
            if (fail_count_o < 10) begin
              $display("ERROR: result %0d: pixel_index exp %0d got %0d, last_out exp %0b got %0b",
                       checked_o, exp_r.pixel_index, result_i.pixel_index,
                       exp_r.last_out, result_i.last_out);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_bins.size();
    end
  end

endmodule

// File: test/tb_rotated_box_pixel_binner.sv
// Testbench top for the rotated box pixel binner: stimulus, register settings and verdict.
`timescale 1ns / 1ps
module tb_rotated_box_pixel_binner;
  import rbpb_pkg::*;

  localparam int LATENCY        = 7;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int RANDOM_SAMPLES = 950;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  sample_t              sample_beat;
  logic                 done;
  result_t              result_beat;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count, pending, checked, hits;
  int cycles = 0;
  int samples_sent, settings_applied, writes_done, first_random, batch;
  bit burst;

  // current setting, kept to aim samples at the box
  int cur_cos, cur_sin, cur_org_x, cur_org_y, cur_wx, cur_wy;

  rotated_box_pixel_binner u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sample_i    (sample_beat),
    .done_o      (done),
    .result_o    (result_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rbpb_bin_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .sample_i     (sample_beat),
    .done_i       (done),
    .result_i     (result_beat),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .inside_o     (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_beat <= {x, y, last};
    start       <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // leaves valid high so that back-to-back writes keep it asserted without a drop between them
  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    writes_done++;
  endtask

  task automatic apply_setting(int c, int s, int ox, int oy, logic [BPU_W-1:0] bx,
                               logic [BPU_W-1:0] by, int cx, int cy, int wx, int wy);
    cur_cos   = c;
    cur_sin   = s;
    cur_org_x = ox;
    cur_org_y = oy;
    cur_wx    = wx;
    cur_wy    = wy;
    cfg_write(CFG_COS_ANGLE, 32'(c));
    cfg_write(CFG_SIN_ANGLE, 32'(s));
    cfg_write(CFG_ORIGIN_X, 32'(ox));
    cfg_write(CFG_ORIGIN_Y, 32'(oy));
    cfg_write(CFG_BINS_PER_UNIT_X, bx);
    cfg_write(CFG_BINS_PER_UNIT_Y, by);
    cfg_write(CFG_BIN_COUNT_X, 32'(cx));
    cfg_write(CFG_BIN_COUNT_Y, 32'(cy));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // pick a point around the box in rotated space and rotate it back
  task automatic send_aimed();
    longint xr, yr, t, q;
    xr = longint'(cur_org_x) + longint'($urandom_range(0, cur_wx + cur_wx / 4)) - cur_wx / 8;
    yr = longint'(cur_org_y) + longint'($urandom_range(0, cur_wy + cur_wy / 4)) - cur_wy / 8;
    t  = (xr * cur_cos + yr * cur_sin) >>> ANGLE_FRAC_BITS;
    q  = (yr * cur_cos - xr * cur_sin) >>> ANGLE_FRAC_BITS;
    send_sample(t[COORD_W-1:0], q[COORD_W-1:0], $urandom_range(0, 7) == 0);
  endtask

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? int'($urandom_range(1000, 2047)) : 0;
      1:       return MAX_BINS_X;
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  task automatic random_setting();
    real               ang;
    logic signed [17:0] raw;
    int                c, s, ox, oy, cx, cy, wx, wy;
    logic [BPU_W-1:0]  bx, by;
    if ($urandom_range(0, 5) == 0) begin
      raw = 18'($urandom);
      c   = int'(raw);
      raw = 18'($urandom);
      s   = int'(raw);
    end else begin
      ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      c   = $rtoi($floor(65536.0 * $cos(ang) + 0.5));
      s   = $rtoi($floor(65536.0 * $sin(ang) + 0.5));
    end
    cx = pick_count();
    cy = pick_count();
    // width above the count keeps bins per unit inside 32 bits
    wx = $urandom_range(1, 1 << 20) + cx;
    wy = $urandom_range(1, 1 << 20) + cy;
    bx = (cx == 0) ? '0 : BPU_W'((longint'(cx) << 32) / wx);
    by = (cy == 0) ? '0 : BPU_W'((longint'(cy) << 32) / wy);
    if ($urandom_range(0, 9) == 0) bx = $urandom;
    if ($urandom_range(0, 9) == 0) by = $urandom;
    ox = ($urandom_range(0, 7) == 0) ? int'($urandom) : int'($urandom_range(0, 1 << 27)) - (1 << 26);
    oy = ($urandom_range(0, 7) == 0) ? int'($urandom) : int'($urandom_range(0, 1 << 27)) - (1 << 26);
    apply_setting(c, s, ox, oy, bx, by, cx, cy, wx, wy);
  endtask

  initial begin
    samples_sent     = 0;
    settings_applied = 0;
    writes_done      = 0;
    burst            = 1'b0;
    cur_cos          = 65536;
    cur_sin          = 0;
    cur_org_x        = 0;
    cur_org_y        = 0;
    cur_wx           = 65536;
    cur_wy           = 65536;
    rst_ni           = 1'b0;
    start            = 1'b0;
    sample_beat      = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset setting: a single pixel over the open unit square
    send_sample(32'd1, 32'd1, 1'b0);
    send_sample(32'd0, 32'd1, 1'b0);
    send_sample(32'd65535, 32'd65535, 1'b1);
    send_sample(32'd65536, 32'd1, 1'b0);
    wait_drained();

    // 4 x 3 grid, one bin per unit: corners and both strict edges
    apply_setting(65536, 0, 0, 0, 32'd65536, 32'd65536, 4, 3, 4 * 65536, 3 * 65536);
    send_sample(32'd1, 32'd1, 1'b0);
    send_sample(32'd262143, 32'd196607, 1'b0);
    send_sample(32'd262144, 32'd1, 1'b0);
    send_sample(32'd1, 32'd196608, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_sample(32'd131077, 32'd65536, 1'b1);
    wait_drained();

    // register extremes, zero bins per unit and a zero row count
    apply_setting(-65536, 65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                  2047, 0, 4096, 4096);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'd0, 32'd0, 1'b0);
    wait_drained();

    // counts above the maximum saturate; top corner gives the largest index
    apply_setting(65536, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2047, 2047, 1024, 1024);
    send_sample(32'd1024, 32'd1024, 1'b0);
    send_sample(32'd1025, 32'd1, 1'b1);
    send_sample(32'd1, 32'd1, 1'b0);
    wait_drained();

    // cosine and sine beyond one are used as given
    apply_setting(131071, -131072, 0, 0, 32'd65536, 32'd65536, 8, 8, 8 * 65536, 8 * 65536);
    send_aimed();
    send_aimed();

    first_random = samples_sent;
    while (samples_sent - first_random < RANDOM_SAMPLES) begin
      wait_drained();
      random_setting();
      burst = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(40, 120);
      repeat (batch) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample($urandom, $urandom, 1'($urandom));
        end else begin
          send_aimed();
        end
      end
    end

    wait_drained();
    repeat (LATENCY + 3) @(negedge clk_i);
    $display("Run covered %0d samples under %0d register settings (%0d register writes).",
             samples_sent, settings_applied, writes_done);
    $display("%0d results checked, %0d of them inside the box.", checked, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
